[rtl/core/clock_alarm_countdown_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the clock/alarm/countdown block
// Shared concurrent assertion forms used by the state core.
// ----------------------------------------------------------------------------
`ifndef CLOCK_ALARM_COUNTDOWN_ASSERT_SVH
`define CLOCK_ALARM_COUNTDOWN_ASSERT_SVH

// Check an expression at every clock edge outside reset.
`define CAC_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define CAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cac_pkg.sv]
// ----------------------------------------------------------------------------
// cac_pkg
// Types, codes and wrap-step helpers for the clock/alarm/countdown block.
// ----------------------------------------------------------------------------
package cac_pkg;

    // Action codes
    localparam logic [3:0] ACT_MIN_TICK  = 4'd0;
    localparam logic [3:0] ACT_SEC_TICK  = 4'd1;
    localparam logic [3:0] ACT_ADJ_CMIN  = 4'd2;
    localparam logic [3:0] ACT_ADJ_CHOUR = 4'd3;
    localparam logic [3:0] ACT_ADJ_AMIN  = 4'd4;
    localparam logic [3:0] ACT_ADJ_AHOUR = 4'd5;
    localparam logic [3:0] ACT_ADJ_TMIN  = 4'd6;
    localparam logic [3:0] ACT_ADJ_THOUR = 4'd7;
    localparam logic [3:0] ACT_ACK       = 4'd8;

    // Direction codes
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    // Wrap limits
    localparam logic [5:0] MIN_MOD   = 6'd60;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_MOD  = 5'd24;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    // Reset values
    localparam logic [4:0] RST_CLOCK_HOUR = 5'd7;
    localparam logic [5:0] RST_CLOCK_MIN  = 6'd30;
    localparam logic [4:0] RST_ALARM_HOUR = 5'd12;
    localparam logic [5:0] RST_ALARM_MIN  = 6'd22;
    localparam logic [4:0] RST_TIMER_HOUR = 5'd0;
    localparam logic [5:0] RST_TIMER_MIN  = 6'd10;

    typedef struct packed {
        logic [3:0]        action;
        logic signed [1:0] direction;
        logic              clock_hold;
        logic              timer_hold;
        logic              count_by_minute;
        logic              count_by_second;
    } cac_item_t;

    typedef struct packed {
        logic [4:0] clock_hours;
        logic [5:0] clock_minutes;
        logic [4:0] alarm_hours;
        logic [5:0] alarm_minutes;
        logic [4:0] timer_hours;
        logic [5:0] timer_minutes;
        logic       alarm_match;
        logic       timer_done;
    } cac_result_t;

    // Step a minute value by +1/-1 with wrap; other directions hold.
    function automatic logic [5:0] min_step(input logic [5:0] v,
                                            input logic signed [1:0] dir);
        logic [6:0] inc;
        logic [5:0] res;
        inc = {1'b0, v} + 7'd1;
        res = v;
        if (dir == DIR_UP) begin
            res = (inc >= {1'b0, MIN_MOD}) ? 6'd0 : inc[5:0];
        end else if (dir == DIR_DOWN) begin
            res = (v == 6'd0 || v >= MIN_MOD) ? MIN_LAST : v - 6'd1;
        end
        return res;
    endfunction

    // Step an hour value by +1/-1 with wrap; other directions hold.
    function automatic logic [4:0] hour_step(input logic [4:0] v,
                                             input logic signed [1:0] dir);
        logic [5:0] inc;
        logic [4:0] res;
        inc = {1'b0, v} + 6'd1;
        res = v;
        if (dir == DIR_UP) begin
            res = (inc >= {1'b0, HOUR_MOD}) ? 5'd0 : inc[4:0];
        end else if (dir == DIR_DOWN) begin
            res = (v == 5'd0 || v >= HOUR_MOD) ? HOUR_LAST : v - 5'd1;
        end
        return res;
    endfunction

endpackage

[rtl/core/clock_alarm_countdown.sv]
// ----------------------------------------------------------------------------
// clock_alarm_countdown
// 24-hour clock with alarm compare and countdown timer, one result per item.
// ----------------------------------------------------------------------------
//  channel | ports        | content
//  --------+--------------+----------------------------------------------------
//  input   | s_valid/ready| action, direction, hold and count-select flags
//  result  | m_valid/ready| clock, alarm, timer fields, match and done flags
//
//  An item is processed from the input register when the output register is
//  free or draining, and its result is loaded into the output register;
//  one item per cycle is sustained while m_ready stays high.
//  The state update is a single pass of wrap adders and compares.
//  Reset (aresetn low, synchronous) loads the clock 07:30, alarm 12:22,
//  timer 00:10 and clears both flags and both pipeline valids.
//  A stall on m_ready holds the result; the input register still takes one
//  more item, then s_ready drops until the result is transferred.
// ----------------------------------------------------------------------------
module clock_alarm_countdown
    import cac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_action,
    input  logic signed [1:0] s_direction,
    input  logic              s_clock_hold,
    input  logic              s_timer_hold,
    input  logic              s_count_by_minute,
    input  logic              s_count_by_second,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [4:0]        m_clock_hours,
    output logic [5:0]        m_clock_minutes,
    output logic [4:0]        m_alarm_hours,
    output logic [5:0]        m_alarm_minutes,
    output logic [4:0]        m_timer_hours,
    output logic [5:0]        m_timer_minutes,
    output logic              m_alarm_match,
    output logic              m_timer_done
);

    cac_item_t   s_item;
    cac_item_t   item;
    logic        item_valid;
    logic        fire;
    cac_result_t state_next;

    logic        m_valid_reg, m_valid_next;
    cac_result_t result_reg;

    // Gather the input ports into one item
    assign s_item.action          = s_action;
    assign s_item.direction       = s_direction;
    assign s_item.clock_hold      = s_clock_hold;
    assign s_item.timer_hold      = s_timer_hold;
    assign s_item.count_by_minute = s_count_by_minute;
    assign s_item.count_by_second = s_count_by_second;

    // Advance the held item when the output register is free or draining
    assign fire = item_valid && (!m_valid_reg || m_ready);

    cac_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    cac_state_core u_state_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item),
        .state_next (state_next)
    );

    // Output register: load on advance, drop after the transfer
    assign m_valid_next = fire ? 1'b1 : ((m_valid_reg && m_ready) ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= state_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_clock_hours   = result_reg.clock_hours;
    assign m_clock_minutes = result_reg.clock_minutes;
    assign m_alarm_hours   = result_reg.alarm_hours;
    assign m_alarm_minutes = result_reg.alarm_minutes;
    assign m_timer_hours   = result_reg.timer_hours;
    assign m_timer_minutes = result_reg.timer_minutes;
    assign m_alarm_match   = result_reg.alarm_match;
    assign m_timer_done    = result_reg.timer_done;

endmodule

[rtl/core/cac_in_stage.sv]
// ----------------------------------------------------------------------------
// cac_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module cac_in_stage
    import cac_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cac_item_t s_item,
    input  logic      take,
    output logic      item_valid,
    output cac_item_t item
);

    logic      vld_reg;
    logic      vld_next;
    cac_item_t item_reg;

    // Free slot, or the held item leaves this cycle
    assign s_ready  = !vld_reg || take;
    assign vld_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

[rtl/core/cac_state_core.sv]
// ----------------------------------------------------------------------------
// cac_state_core
// Clock, alarm and countdown state with its one-pass update logic.
// ----------------------------------------------------------------------------
`include "clock_alarm_countdown_assert.svh"

module cac_state_core
    import cac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  cac_item_t   item,
    output cac_result_t state_next
);

    logic [4:0] clock_hour_reg, clock_hour_next;
    logic [5:0] clock_min_reg, clock_min_next;
    logic [4:0] alarm_hour_reg, alarm_hour_next;
    logic [5:0] alarm_min_reg, alarm_min_next;
    logic [4:0] timer_hour_reg, timer_hour_next;
    logic [5:0] timer_min_reg, timer_min_next;
    logic       match_reg, match_next;
    logic       done_reg, done_next;

    logic       count_en;
    logic [5:0] adv_min;
    logic [4:0] adv_hour;
    logic [5:0] cd_min;
    logic [4:0] cd_hour;

    logic        fields_ok;
    logic        count_fire;
    logic        done_quiet;
    logic        ack_fire;
    logic [12:0] watch_bits;

    // Countdown on the tick that matches the selected rate
    assign count_en = !item.timer_hold &&
                      ((item.action == ACT_MIN_TICK && item.count_by_minute) ||
                       (item.action == ACT_SEC_TICK && item.count_by_second));

    // Clock advance: carry into hours when minutes wrap
    assign adv_min  = min_step(clock_min_reg, DIR_UP);
    assign adv_hour = (adv_min == 6'd0) ? hour_step(clock_hour_reg, DIR_UP)
                                        : clock_hour_reg;

    // Countdown: hours stop at zero, minutes wrap to 59
    assign cd_min  = (timer_min_reg == 6'd0) ? MIN_LAST : timer_min_reg - 6'd1;
    assign cd_hour = (timer_min_reg == 6'd0 && timer_hour_reg != 5'd0) ?
                     timer_hour_reg - 5'd1 : timer_hour_reg;

    always_comb begin
        clock_hour_next = clock_hour_reg;
        clock_min_next  = clock_min_reg;
        alarm_hour_next = alarm_hour_reg;
        alarm_min_next  = alarm_min_reg;
        timer_hour_next = timer_hour_reg;
        timer_min_next  = timer_min_reg;
        match_next      = match_reg;
        done_next       = done_reg;
        unique case (item.action)
            ACT_MIN_TICK: begin
                if (!item.clock_hold) begin
                    clock_min_next  = adv_min;
                    clock_hour_next = adv_hour;
                    match_next      = (adv_hour == alarm_hour_reg) &&
                                      (adv_min == alarm_min_reg);
                end
            end
            ACT_ADJ_CMIN:  clock_min_next  = min_step(clock_min_reg, item.direction);
            ACT_ADJ_CHOUR: clock_hour_next = hour_step(clock_hour_reg, item.direction);
            ACT_ADJ_AMIN:  alarm_min_next  = min_step(alarm_min_reg, item.direction);
            ACT_ADJ_AHOUR: alarm_hour_next = hour_step(alarm_hour_reg, item.direction);
            ACT_ADJ_TMIN:  timer_min_next  = min_step(timer_min_reg, item.direction);
            ACT_ADJ_THOUR: timer_hour_next = hour_step(timer_hour_reg, item.direction);
            ACT_ACK:       done_next       = 1'b0;
            default: ;
        endcase
        if (count_en) begin
            timer_min_next  = cd_min;
            timer_hour_next = cd_hour;
            if (cd_min == 6'd0 && cd_hour == 5'd0) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hour_reg <= RST_CLOCK_HOUR;
            clock_min_reg  <= RST_CLOCK_MIN;
            alarm_hour_reg <= RST_ALARM_HOUR;
            alarm_min_reg  <= RST_ALARM_MIN;
            timer_hour_reg <= RST_TIMER_HOUR;
            timer_min_reg  <= RST_TIMER_MIN;
            match_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end else if (fire) begin
            clock_hour_reg <= clock_hour_next;
            clock_min_reg  <= clock_min_next;
            alarm_hour_reg <= alarm_hour_next;
            alarm_min_reg  <= alarm_min_next;
            timer_hour_reg <= timer_hour_next;
            timer_min_reg  <= timer_min_next;
            match_reg      <= match_next;
            done_reg       <= done_next;
        end
    end

    assign state_next.clock_hours   = clock_hour_next;
    assign state_next.clock_minutes = clock_min_next;
    assign state_next.alarm_hours   = alarm_hour_next;
    assign state_next.alarm_minutes = alarm_min_next;
    assign state_next.timer_hours   = timer_hour_next;
    assign state_next.timer_minutes = timer_min_next;
    assign state_next.alarm_match   = match_next;
    assign state_next.timer_done    = done_next;

    // Terms watched by the checks below
    assign fields_ok  = (clock_min_reg < MIN_MOD) && (alarm_min_reg < MIN_MOD) &&
                        (timer_min_reg < MIN_MOD) && (clock_hour_reg < HOUR_MOD) &&
                        (alarm_hour_reg < HOUR_MOD) && (timer_hour_reg < HOUR_MOD);
    assign count_fire = fire && count_en;
    assign done_quiet = !done_reg && !count_fire;
    assign ack_fire   = fire && (item.action == ACT_ACK);
    assign watch_bits = {clock_min_reg, timer_min_reg, done_reg};

    `CAC_ASSERT_ALWAYS(a_fields_in_range, aclk, aresetn, fields_ok, "time field out of range")
    `CAC_ASSERT_NEXT(a_done_rise_src, aclk, aresetn, done_quiet, !done_reg, "stray done flag")
    `CAC_ASSERT_NEXT(a_ack_clears, aclk, aresetn, ack_fire, !done_reg, "ack left done set")
    `CAC_ASSERT_NEXT(a_idle_holds, aclk, aresetn, !fire, $stable(watch_bits), "idle state moved")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: clock_alarm_countdown
// Self-checking bench for the clock, alarm and countdown block. Every transfer
// is run through a local copy of the clock state, and each result transfer is
// checked field by field against the oldest prediction. Both sides idle at
// random; the closing phase runs back to back.
// ----------------------------------------------------------------------------
module tb;
    import cac_pkg::*;

    localparam int          HALF_PERIOD = 4;
    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [3:0]  ACT_TOP     = 4'hF;
    localparam logic [3:0]  ACT_SPARE   = ACT_ACK + 4'd1;
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_BAD  = 2'sb10;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [3:0]        s_action          = ACT_MIN_TICK;
    logic signed [1:0] s_direction       = DIR_NONE;
    logic              s_clock_hold      = 1'b0;
    logic              s_timer_hold      = 1'b0;
    logic              s_count_by_minute = 1'b0;
    logic              s_count_by_second = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b1;
    logic [4:0]        m_clock_hours;
    logic [5:0]        m_clock_minutes;
    logic [4:0]        m_alarm_hours;
    logic [5:0]        m_alarm_minutes;
    logic [4:0]        m_timer_hours;
    logic [5:0]        m_timer_minutes;
    logic              m_alarm_match;
    logic              m_timer_done;

    always #(HALF_PERIOD) aclk = ~aclk;

    clock_alarm_countdown dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_direction       (s_direction),
        .s_clock_hold      (s_clock_hold),
        .s_timer_hold      (s_timer_hold),
        .s_count_by_minute (s_count_by_minute),
        .s_count_by_second (s_count_by_second),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_clock_hours     (m_clock_hours),
        .m_clock_minutes   (m_clock_minutes),
        .m_alarm_hours     (m_alarm_hours),
        .m_alarm_minutes   (m_alarm_minutes),
        .m_timer_hours     (m_timer_hours),
        .m_timer_minutes   (m_timer_minutes),
        .m_alarm_match     (m_alarm_match),
        .m_timer_done      (m_timer_done)
    );

    // ------------------------------------------------------------------------
    // Predicted clock state and the readings still owed by the block
    // ------------------------------------------------------------------------
    int          clk_hr   = RST_CLOCK_HOUR;
    int          clk_min  = RST_CLOCK_MIN;
    int          alm_hr   = RST_ALARM_HOUR;
    int          alm_min  = RST_ALARM_MIN;
    int          tmr_hr   = RST_TIMER_HOUR;
    int          tmr_min  = RST_TIMER_MIN;
    bit          match_now = 1'b0;
    bit          done_now  = 1'b0;
    cac_result_t expected_readings[$];

    int          errors          = 0;
    int          sent_count      = 0;
    int          results_checked = 0;
    int          matches_seen    = 0;
    int          runouts_seen    = 0;
    int          cycle_count     = 0;
    bit          idle_on         = 1'b0;
    int          ready_hold      = 0;

    // Step a field by one with wrap over 0..last; any other direction holds it.
    function automatic int wrap_step(input int v, input logic signed [1:0] dir,
                                     input int last);
        if (dir == DIR_UP)
            return (v >= last) ? 0 : v + 1;
        if (dir == DIR_DOWN)
            return (v == 0 || v > last) ? last : v - 1;
        return v;
    endfunction

    // Count the timer down once; the hour sticks at zero when the minute wraps.
    task automatic tick_timer();
        if (tmr_min == 0) begin
            tmr_min = MIN_LAST;
            if (tmr_hr != 0)
                tmr_hr = tmr_hr - 1;
        end else begin
            tmr_min = tmr_min - 1;
        end
        if (tmr_hr == 0 && tmr_min == 0) begin
            done_now = 1'b1;
            runouts_seen++;
        end
    endtask

    // Apply one accepted transfer to the predicted state and queue its reading.
    task automatic apply_action(input cac_item_t it);
        cac_result_t r;
        case (it.action)
            ACT_MIN_TICK: begin
                if (!it.clock_hold) begin
                    clk_min = wrap_step(clk_min, DIR_UP, MIN_LAST);
                    if (clk_min == 0)
                        clk_hr = wrap_step(clk_hr, DIR_UP, HOUR_LAST);
                    match_now = (clk_hr == alm_hr && clk_min == alm_min);
                    if (match_now)
                        matches_seen++;
                end
                if (!it.timer_hold && it.count_by_minute)
                    tick_timer();
            end
            ACT_SEC_TICK: begin
                if (!it.timer_hold && it.count_by_second)
                    tick_timer();
            end
            ACT_ADJ_CMIN:  clk_min = wrap_step(clk_min, it.direction, MIN_LAST);
            ACT_ADJ_CHOUR: clk_hr  = wrap_step(clk_hr,  it.direction, HOUR_LAST);
            ACT_ADJ_AMIN:  alm_min = wrap_step(alm_min, it.direction, MIN_LAST);
            ACT_ADJ_AHOUR: alm_hr  = wrap_step(alm_hr,  it.direction, HOUR_LAST);
            ACT_ADJ_TMIN:  tmr_min = wrap_step(tmr_min, it.direction, MIN_LAST);
            ACT_ADJ_THOUR: tmr_hr  = wrap_step(tmr_hr,  it.direction, HOUR_LAST);
            ACT_ACK:       done_now = 1'b0;
            default: ;
        endcase
        r.clock_hours   = 5'(clk_hr);
        r.clock_minutes = 6'(clk_min);
        r.alarm_hours   = 5'(alm_hr);
        r.alarm_minutes = 6'(alm_min);
        r.timer_hours   = 5'(tmr_hr);
        r.timer_minutes = 6'(tmr_min);
        r.alarm_match   = match_now;
        r.timer_done    = done_now;
        expected_readings.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic cac_item_t make_item(input logic [3:0] act,
                                            input logic signed [1:0] dir,
                                            input bit ch, input bit th,
                                            input bit bm, input bit bs);
        cac_item_t it;
        it.action          = act;
        it.direction       = dir;
        it.clock_hold      = ch;
        it.timer_hold      = th;
        it.count_by_minute = bm;
        it.count_by_second = bs;
        return it;
    endfunction

    // Fully random item, every field over its whole encoding.
    function automatic cac_item_t random_item();
        return make_item(4'($urandom_range(0, ACT_TOP)), 2'($urandom_range(0, 3)),
                         1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // Drive one item, hold it until the transfer, predict it, then maybe idle.
    // Called at a rising edge; returns at a rising edge.
    task automatic push_item(input cac_item_t it);
        int gap;
        s_valid           <= 1'b1;
        s_action          <= it.action;
        s_direction       <= it.direction;
        s_clock_hold      <= it.clock_hold;
        s_timer_hold      <= it.timer_hold;
        s_count_by_minute <= it.count_by_minute;
        s_count_by_second <= it.count_by_second;
        do @(posedge aclk); while (!s_ready);
        apply_action(it);
        sent_count++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic int field_now(input logic [3:0] act);
        case (act)
            ACT_ADJ_CMIN:  return clk_min;
            ACT_ADJ_CHOUR: return clk_hr;
            ACT_ADJ_AMIN:  return alm_min;
            ACT_ADJ_AHOUR: return alm_hr;
            ACT_ADJ_TMIN:  return tmr_min;
            default:       return tmr_hr;
        endcase
    endfunction

    // Walk one adjustable field to a target along the shorter way round.
    task automatic walk_field(input logic [3:0] act, input int target);
        int        modulus;
        int        fwd;
        cac_item_t it;
        modulus = (act == ACT_ADJ_CMIN || act == ACT_ADJ_AMIN || act == ACT_ADJ_TMIN)
                  ? MIN_MOD : HOUR_MOD;
        fwd = (target - field_now(act) + modulus) % modulus;
        while (field_now(act) != target) begin
            it           = random_item();
            it.action    = act;
            it.direction = (fwd <= modulus / 2) ? DIR_UP : DIR_DOWN;
            push_item(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset readback, every action, every direction code, holds and selects.
    task automatic test_directed_cases();
        // unused, reset state
        push_item(make_item(ACT_TOP,       DIR_BAD,  1'b1, 1'b1, 1'b1, 1'b1));
        push_item(make_item(ACT_SPARE,     DIR_UP,   1'b0, 1'b0, 1'b0, 1'b0)); // unused
        push_item(make_item(ACT_ADJ_CMIN,  DIR_UP,   1'b0, 1'b0, 1'b0, 1'b0));
        push_item(make_item(ACT_ADJ_CMIN,  DIR_DOWN, 1'b1, 1'b1, 1'b1, 1'b1));
        push_item(make_item(ACT_ADJ_CHOUR, DIR_NONE, 1'b0, 1'b0, 1'b0, 1'b0)); // no step
        push_item(make_item(ACT_ADJ_CHOUR, DIR_BAD,  1'b0, 1'b0, 1'b0, 1'b0)); // no step
        // 0 wraps to 23, then 23 wraps to 0
        push_item(make_item(ACT_ADJ_THOUR, DIR_DOWN, 1'b0, 1'b0, 1'b0, 1'b0));
        push_item(make_item(ACT_ADJ_THOUR, DIR_UP,   1'b0, 1'b0, 1'b0, 1'b0));
        push_item(make_item(ACT_ADJ_AMIN,  DIR_UP,   1'b0, 1'b1, 1'b0, 1'b1));
        push_item(make_item(ACT_ADJ_AHOUR, DIR_DOWN, 1'b1, 1'b0, 1'b1, 1'b0));
        push_item(make_item(ACT_ADJ_TMIN,  DIR_DOWN, 1'b0, 1'b0, 1'b0, 1'b0));
        push_item(make_item(ACT_ADJ_TMIN,  DIR_BAD,  1'b0, 1'b0, 1'b0, 1'b0));
        // clock held while the timer still counts on the same tick
        push_item(make_item(ACT_MIN_TICK,  DIR_BAD,  1'b1, 1'b0, 1'b1, 1'b0));
        push_item(make_item(ACT_MIN_TICK,  DIR_UP,   1'b0, 1'b1, 1'b1, 1'b1)); // timer held
        push_item(make_item(ACT_MIN_TICK,  DIR_DOWN, 1'b0, 1'b0, 1'b0, 1'b1)); // wrong select
        push_item(make_item(ACT_MIN_TICK,  DIR_NONE, 1'b0, 1'b0, 1'b1, 1'b1)); // both selects
        push_item(make_item(ACT_SEC_TICK,  DIR_NONE, 1'b0, 1'b0, 1'b1, 1'b1)); // both selects
        push_item(make_item(ACT_SEC_TICK,  DIR_UP,   1'b1, 1'b0, 1'b1, 1'b0)); // wrong select
        push_item(make_item(ACT_SEC_TICK,  DIR_DOWN, 1'b0, 1'b1, 1'b0, 1'b1)); // timer held
        // ack with no done
        push_item(make_item(ACT_ACK,       DIR_BAD,  1'b1, 1'b1, 1'b1, 1'b1));
    endtask

    // Random items over every encoding, ticks favored so the clock moves.
    task automatic test_random_mix(input int count);
        cac_item_t it;
        repeat (count) begin
            it = random_item();
            if ($urandom_range(0, 2) == 0)
                it.action = 4'($urandom_range(ACT_MIN_TICK, ACT_SEC_TICK));
            push_item(it);
        end
    endtask

    // Set the clock one minute short of the alarm, then tick into and out of it.
    // The first round puts the alarm at midnight to force the hour rollover.
    task automatic test_alarm_match(input int rounds);
        int        ah;
        int        am;
        cac_item_t it;
        for (int n = 0; n < rounds; n++) begin
            ah = (n == 0) ? 0 : $urandom_range(0, HOUR_LAST);
            am = (n == 0) ? 0 : $urandom_range(0, MIN_LAST);
            walk_field(ACT_ADJ_AHOUR, ah);
            walk_field(ACT_ADJ_AMIN, am);
            walk_field(ACT_ADJ_CHOUR, (am == 0) ? (ah + HOUR_LAST) % HOUR_MOD : ah);
            walk_field(ACT_ADJ_CMIN, (am == 0) ? MIN_LAST : am - 1);
            // a held tick first now and then, so the match lands on a later one
            if ($urandom_range(0, 2) == 0) begin
                it = random_item();
                it.action = ACT_MIN_TICK;
                it.clock_hold = 1'b1;
                push_item(it);
            end
            it = random_item();
            it.action = ACT_MIN_TICK;
            it.clock_hold = 1'b0;
            push_item(it);
            it = random_item();
            it.action = ACT_MIN_TICK;
            push_item(it);
        end
    endtask

    // Bring the timer near zero and count it down toward zero, then acknowledge.
    task automatic test_timer_runout(input int rounds);
        cac_item_t it;
        bit        by_sec;
        for (int n = 0; n < rounds; n++) begin
            walk_field(ACT_ADJ_THOUR, $urandom_range(0, 1));
            walk_field(ACT_ADJ_TMIN, $urandom_range(0, 3));
            repeat ($urandom_range(2, 7)) begin
                by_sec = 1'($urandom);
                it = random_item();
                it.action = by_sec ? ACT_SEC_TICK : ACT_MIN_TICK;
                it.timer_hold = ($urandom_range(0, 5) == 0);
                if (by_sec)
                    it.count_by_second = 1'b1;
                else
                    it.count_by_minute = 1'b1;
                push_item(it);
            end
            it = random_item();
            it.action = ACT_ACK;
            push_item(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts on m_ready, idling phase only
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 9);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, want %0d (result %0d)",
                 $realtime, what, got, want, results_checked);
    endtask

    // Check every result transfer against the oldest pending reading.
    always @(posedge aclk) begin
        cac_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                flag_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = expected_readings.pop_front();
                if (m_clock_hours !== want.clock_hours)
                    flag_mismatch("clock_hours", m_clock_hours, want.clock_hours);
                if (m_clock_minutes !== want.clock_minutes)
                    flag_mismatch("clock_minutes", m_clock_minutes, want.clock_minutes);
                if (m_alarm_hours !== want.alarm_hours)
                    flag_mismatch("alarm_hours", m_alarm_hours, want.alarm_hours);
                if (m_alarm_minutes !== want.alarm_minutes)
                    flag_mismatch("alarm_minutes", m_alarm_minutes, want.alarm_minutes);
                if (m_timer_hours !== want.timer_hours)
                    flag_mismatch("timer_hours", m_timer_hours, want.timer_hours);
                if (m_timer_minutes !== want.timer_minutes)
                    flag_mismatch("timer_minutes", m_timer_minutes, want.timer_minutes);
                if (m_alarm_match !== want.alarm_match)
                    flag_mismatch("alarm_match", m_alarm_match, want.alarm_match);
                if (m_timer_done !== want.timer_done)
                    flag_mismatch("timer_done", m_timer_done, want.timer_done);
                results_checked++;
            end
        end
    end

    // Watchdog: end the run at the cycle limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog expired with %0d readings pending",
                     expected_readings.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        // hold reset low from the start, then release it once
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // idling phase: gaps on the input side, stalls on the result side
        idle_on = 1'b1;
        test_directed_cases();
        test_random_mix(120);
        test_alarm_match(4);
        test_timer_runout(6);
        test_random_mix(60);

        // closing phase: back-to-back transfers, no stalls
        idle_on = 1'b0;
        test_timer_runout(2);
        test_random_mix(80);
        s_valid <= 1'b0;

        // drain pending readings, then let the two-stage pipeline settle
        while (expected_readings.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("sent %0d transfers, checked %0d results", sent_count, results_checked);
        $display("alarm matches %0d, timer run-outs %0d", matches_seen, runouts_seen);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
